// ----- src/cref_pkg.sv -----
// cref_pkg: shared constants, word types and memory port bundles for the
// CSR reverse edge finder. No dependencies; cref_ctrl and csr_reverse_edge_finder import it.
package cref_pkg;

    // Table sizes
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;

    // Field widths
    localparam int VTX_W  = 11;
    localparam int OFS_W  = 13;
    localparam int SLOT_W = 12;
    localparam int NB_W   = 10;

    // Memory address widths
    localparam int OFS_AW  = $clog2(MAX_VERTICES + 1);
    localparam int EDGE_AW = $clog2(MAX_EDGES);

    // Command codes
    typedef enum logic [1:0] {
        CMD_WR_OFS  = 2'd0,
        CMD_WR_EDGE = 2'd1,
        CMD_FIND    = 2'd2,
        CMD_REVERSE = 2'd3
    } cmd_t;

    // Command word
    typedef struct packed {
        cmd_t              command;
        logic [VTX_W-1:0]  vertex;
        logic [OFS_W-1:0]  offset_value;
        logic [SLOT_W-1:0] edge_slot;
        logic [NB_W-1:0]   neighbor;
    } cmd_word_t;

    // Response word
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] position;
        logic [NB_W-1:0]   neighbor_read;
    } rsp_word_t;

    // Offset table port bundle
    typedef struct packed {
        logic              we;
        logic [OFS_AW-1:0] waddr;
        logic [OFS_W-1:0]  wdata;
        logic              re;
        logic [OFS_AW-1:0] raddr;
    } ofs_port_t;

    // Edge table port bundle
    typedef struct packed {
        logic               we;
        logic [EDGE_AW-1:0] waddr;
        logic [NB_W-1:0]    wdata;
        logic               re;
        logic [EDGE_AW-1:0] raddr;
    } edge_port_t;

    // Run bounds saturate at the edge table size
    function automatic logic [OFS_W-1:0] clamp_slot(logic [OFS_W-1:0] s);
        logic [OFS_W-1:0] lim;
        lim = OFS_W'(MAX_EDGES);
        return (s > lim) ? lim : s;
    endfunction

endpackage

// ----- src/cref_ram.sv -----
// cref_ram: generic simple dual-port synchronous RAM, one write and one
// registered read port. No package dependencies.
module cref_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/cref_ctrl.sv -----
// cref_ctrl: command sequencer; issues table writes, fetches run bounds and
// runs the binary search one probe at a time. Depends on cref_pkg.
module cref_ctrl
    import cref_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_word_t        cmd_word,
    output logic             res_valid,
    input  logic             res_ready,
    output rsp_word_t        res_word,
    output ofs_port_t        ofs_port,
    input  logic [OFS_W-1:0] ofs_rdata,
    output edge_port_t       edge_port,
    input  logic [NB_W-1:0]  edge_rdata
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SLOT   = 7'b0000010,
        S_OFS_LO = 7'b0000100,
        S_OFS_HI = 7'b0001000,
        S_ISSUE  = 7'b0010000,
        S_PROBE  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t            state_reg,  state_next;
    logic [VTX_W-1:0]  vtx_reg,    vtx_next;
    logic [VTX_W-1:0]  tgt_reg,    tgt_next;
    logic [OFS_W-1:0]  lo_reg,     lo_next;
    logic [OFS_W-1:0]  hi_reg,     hi_next;
    logic [SLOT_W-1:0] mid_reg,    mid_next;
    logic              found_reg,  found_next;
    logic [SLOT_W-1:0] pos_reg,    pos_next;
    logic [NB_W-1:0]   nread_reg,  nread_next;

    logic              accept;
    logic [OFS_W:0]    bound_sum;
    logic [SLOT_W-1:0] mid_calc;
    logic [VTX_W-1:0]  probe_id;

    assign accept    = cmd_valid && cmd_ready;
    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    // lo < hi <= MAX_EDGES keeps the midpoint inside the slot range
    assign mid_calc  = bound_sum[SLOT_W:1];
    assign probe_id  = {{(VTX_W - NB_W){1'b0}}, edge_rdata};

    // Next-state and memory port logic
    always_comb
    begin
        state_next = state_reg;
        vtx_next   = vtx_reg;
        tgt_next   = tgt_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        nread_next = nread_reg;

        ofs_port        = '0;
        ofs_port.waddr  = cmd_word.vertex;
        ofs_port.wdata  = cmd_word.offset_value;
        edge_port       = '0;
        edge_port.waddr = cmd_word.edge_slot;
        edge_port.wdata = cmd_word.neighbor;

        cmd_ready = 1'b0;
        res_valid = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (accept)
                begin
                    found_next = 1'b0;
                    pos_next   = '0;
                    nread_next = '0;
                    case (cmd_word.command)
                        CMD_WR_OFS:
                        begin
                            ofs_port.we = (cmd_word.vertex <= VTX_W'(MAX_VERTICES));
                            state_next  = S_DONE;
                        end
                        CMD_WR_EDGE:
                        begin
                            edge_port.we = 1'b1;
                            state_next   = S_DONE;
                        end
                        CMD_FIND:
                        begin
                            vtx_next = cmd_word.vertex;
                            tgt_next = {{(VTX_W - NB_W){1'b0}}, cmd_word.neighbor};
                            if (cmd_word.vertex < VTX_W'(MAX_VERTICES))
                            begin
                                ofs_port.re    = 1'b1;
                                ofs_port.raddr = cmd_word.vertex;
                                state_next     = S_OFS_LO;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        CMD_REVERSE:
                        begin
                            tgt_next        = cmd_word.vertex;
                            edge_port.re    = 1'b1;
                            edge_port.raddr = cmd_word.edge_slot;
                            state_next      = S_SLOT;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // Neighbor at the given slot becomes the source of the search
            S_SLOT:
            begin
                nread_next     = edge_rdata;
                vtx_next       = probe_id;
                ofs_port.re    = 1'b1;
                ofs_port.raddr = probe_id;
                state_next     = S_OFS_LO;
            end
            S_OFS_LO:
            begin
                lo_next        = clamp_slot(ofs_rdata);
                ofs_port.re    = 1'b1;
                ofs_port.raddr = vtx_reg + VTX_W'(1);
                state_next     = S_OFS_HI;
            end
            S_OFS_HI:
            begin
                hi_next    = clamp_slot(ofs_rdata);
                state_next = S_ISSUE;
            end
            // Empty interval ends the search as a miss
            S_ISSUE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next        = mid_calc;
                    edge_port.re    = 1'b1;
                    edge_port.raddr = mid_calc;
                    state_next      = S_PROBE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PROBE:
            begin
                if (probe_id == tgt_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = mid_reg;
                    state_next = S_DONE;
                end
                else if (probe_id > tgt_reg)
                begin
                    hi_next    = {1'b0, mid_reg};
                    state_next = S_ISSUE;
                end
                else
                begin
                    lo_next    = {1'b0, mid_reg} + OFS_W'(1);
                    state_next = S_ISSUE;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_word.found         = found_reg;
    assign res_word.position      = pos_reg;
    assign res_word.neighbor_read = nread_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Search datapath
    always_ff @(posedge clk)
    begin
        vtx_reg   <= vtx_next;
        tgt_reg   <= tgt_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        nread_reg <= nread_next;
    end

`ifndef NO_ASSERTIONS
    // A table is never written and read in the same cycle
    a_ofs_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ofs_port.we && ofs_port.re))
        else $error("offset table written and read together");

    a_edge_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(edge_port.we && edge_port.re))
        else $error("edge table written and read together");

    // Probe data is only consumed in the cycle after its read was issued
    a_probe_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE && lo_reg < hi_reg) |=> (state_reg == S_PROBE))
        else $error("probe state not reached after read issue");

    // Search bounds stay within the edge table
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |->
            (lo_reg <= OFS_W'(MAX_EDGES) && hi_reg <= OFS_W'(MAX_EDGES)))
        else $error("search bound beyond edge table");

    // An accepted word always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");
`endif

endmodule

// ----- src/csr_reverse_edge_finder.sv -----
// csr_reverse_edge_finder: graph in compressed sparse row form with edge and
// reverse-edge lookup. Depends on cref_pkg, cref_ram and cref_ctrl.
//
// One command word is worked on at a time. A write holds the sequencer for
// the accepting cycle and the hand-off of its response to the output
// register. A find holds it for the accepting cycle, the reads of the low and
// high run bounds, a binary search of up to 13 probes over a 4096-slot run,
// each one edge table read and one compare, a check that sees the interval
// empty on a miss, and the hand-off. A reverse lookup first reads the
// neighbor at the given slot. The response reaches the port in the cycle
// after hand-off; while the output register is full and not drained, the
// sequencer waits in its hand-off state. Both tables are undefined after
// reset and need no clearing pass. The response sits in an output register,
// so a new command is taken while the previous response still waits to be
// consumed.
module csr_reverse_edge_finder
    import cref_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_word_t cmd_word,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp_word
);

    ofs_port_t         ofs_port;
    edge_port_t        edge_port;
    logic [OFS_W-1:0]  ofs_rdata;
    logic [NB_W-1:0]   edge_rdata;
    logic              res_valid;
    logic              res_ready;
    rsp_word_t         res_word;

    logic              rsp_valid_reg, rsp_valid_next;
    rsp_word_t         rsp_word_reg;

    cref_ram #(
        .WIDTH (OFS_W),
        .DEPTH (MAX_VERTICES + 1),
        .AW    (OFS_AW)
    ) u_ofs_ram (
        .clk   (clk),
        .we    (ofs_port.we),
        .waddr (ofs_port.waddr),
        .wdata (ofs_port.wdata),
        .re    (ofs_port.re),
        .raddr (ofs_port.raddr),
        .rdata (ofs_rdata)
    );

    cref_ram #(
        .WIDTH (NB_W),
        .DEPTH (MAX_EDGES),
        .AW    (EDGE_AW)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_port.we),
        .waddr (edge_port.waddr),
        .wdata (edge_port.wdata),
        .re    (edge_port.re),
        .raddr (edge_port.raddr),
        .rdata (edge_rdata)
    );

    cref_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_word   (cmd_word),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_word   (res_word),
        .ofs_port   (ofs_port),
        .ofs_rdata  (ofs_rdata),
        .edge_port  (edge_port),
        .edge_rdata (edge_rdata)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_word_reg <= res_word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule
